// ===== design/vrdv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdv_pkg : shared types and constants for the dual-view video memory
// Field structs, access codes and memory geometry used by all modules.
// ----------------------------------------------------------------------------
package vrdv_pkg;

    // Byte address bits of the memory window; the memory holds 2^ADDR_BITS bytes.
    localparam int ADDR_BITS = 23;
    localparam int IDX_BITS  = ADDR_BITS - 2;
    localparam int MEM_WORDS = 1 << IDX_BITS;

    localparam int PORT_ADDR_W = 23;
    localparam int DATA_W      = 32;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic VIEW_LINEAR = 1'b0;
    localparam logic VIEW_BANKED = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic                   req_type;
        logic                   view;
        logic [1:0]             access_size;
        logic [PORT_ADDR_W-1:0] address;
        logic [DATA_W-1:0]      write_data;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [PORT_ADDR_W-1:0]   physical_address;
    } rsp_t;

    // Translated access as seen by the memory array.
    typedef struct packed {
        logic [IDX_BITS-1:0]    idx;
        logic [1:0]             lane;
        logic [3:0]             byte_en;
        logic [DATA_W-1:0]      wdata;
        logic [PORT_ADDR_W-1:0] phys;
    } xlate_t;

endpackage

// ===== design/video_ram_dual_view_access.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_ram_dual_view_access : video memory with linear and banked views
// Byte, halfword and word accesses through two address views; reads come
// back sign-extended, writes store little-endian bytes under byte enables.
// ----------------------------------------------------------------------------
//  channel   handshake        payload   notes
//  request   start / busy     req       taken when start is high, busy low
//  result    done (strobe)    rsp       valid for the single cycle of done
//
//  One access per cycle; busy stays low.
//  The result strobes in the cycle after the access is taken, set by the
//  registered read port of the word-wide memory array.
//  Reset clears only the result strobe; memory contents are undefined
//  until written, and no clearing pass runs.
//  The receiver cannot stall: each result word is shown for one cycle only.
// ----------------------------------------------------------------------------
module video_ram_dual_view_access
    import vrdv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    xlate_t xl;
    logic   accept;

    logic [DATA_W-1:0] vram_mem [MEM_WORDS];

    logic                   done_reg;
    logic                   done_next;
    logic [DATA_W-1:0]      rdata_reg;
    logic                   is_write_reg;
    logic [1:0]             size_reg;
    logic [1:0]             lane_reg;
    logic [PORT_ADDR_W-1:0] phys_reg;
    logic [DATA_W-1:0]      shifted;
    logic [DATA_W-1:0]      rdata_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    vrdv_xlate u_xlate
    (
        .req (req),
        .xl  (xl)
    );

    // Byte-lane writes and the registered read share the same accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (req.req_type == REQ_WRITE)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (xl.byte_en[i])
                    begin
                        vram_mem[xl.idx][8*i +: 8] <= xl.wdata[8*i +: 8];
                    end
                end
            end
            rdata_reg <= vram_mem[xl.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_write_reg <= req.req_type;
            size_reg     <= req.access_size;
            lane_reg     <= xl.lane;
            phys_reg     <= xl.phys;
        end
    end

    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign shifted = rdata_reg >> {lane_reg, 3'b000};

    always_comb
    begin
        case (size_reg)
            SIZE_BYTE:
            begin
                rdata_ext = {{24{shifted[7]}}, shifted[7:0]};
            end
            SIZE_HALF:
            begin
                rdata_ext = {{16{shifted[15]}}, shifted[15:0]};
            end
            default:
            begin
                rdata_ext = shifted;
            end
        endcase
    end

    assign done                 = done_reg;
    assign rsp.read_data        = (is_write_reg == REQ_WRITE) ? '0 : $signed(rdata_ext);
    assign rsp.physical_address = phys_reg;

endmodule

// ===== design/vrdv_xlate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdv_xlate : address alignment, view translation and lane steering
// Aligns the address to the access size, applies the bank-interleaved view
// and forms the word index, byte enables and replicated write data.
// ----------------------------------------------------------------------------
module vrdv_xlate
    import vrdv_pkg::*;
(
    input  req_t   req,
    output xlate_t xl
);

    logic [ADDR_BITS-1:0] addr_m;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] phys;
    logic [3:0]           be;
    logic [DATA_W-1:0]    wd;

    assign addr_m = ADDR_BITS'(req.address);

    always_comb
    begin
        case (req.access_size)
            SIZE_BYTE:
            begin
                addr_a = addr_m;
            end
            SIZE_HALF:
            begin
                addr_a = {addr_m[ADDR_BITS-1:1], 1'b0};
            end
            default:
            begin
                addr_a = {addr_m[ADDR_BITS-1:2], 2'b00};
            end
        endcase
    end

    // Banked view: bit 2 becomes the bank select at the top, the rest slides down.
    assign phys = (req.view == VIEW_BANKED)
                ? {addr_a[2], addr_a[ADDR_BITS-1:3], addr_a[1:0]}
                : addr_a;

    always_comb
    begin
        case (req.access_size)
            SIZE_BYTE:
            begin
                be = 4'b0001 << phys[1:0];
                wd = {4{req.write_data[7:0]}};
            end
            SIZE_HALF:
            begin
                be = 4'b0011 << phys[1:0];
                wd = {2{req.write_data[15:0]}};
            end
            default:
            begin
                be = 4'b1111;
                wd = req.write_data;
            end
        endcase
    end

    assign xl.idx     = phys[ADDR_BITS-1:2];
    assign xl.lane    = phys[1:0];
    assign xl.byte_en = be;
    assign xl.wdata   = wd;
    assign xl.phys    = PORT_ADDR_W'(phys);

endmodule

// ===== design/vrdv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdv_checker : port-level checks for the dual-view video memory
// Watches the request and result ports for strobe timing and result shape.
// ----------------------------------------------------------------------------
module vrdv_checker
    import vrdv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    // Every taken word gives exactly one result on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without accepted word");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_WRITE) |=> (rsp.read_data == '0))
        else $error("write returned non-zero read data");

    a_byte_sext: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_READ && req.access_size == SIZE_BYTE)
        |=> (rsp.read_data[31:7] == '0 || rsp.read_data[31:7] == '1))
        else $error("byte read not sign-extended");

endmodule

bind video_ram_dual_view_access vrdv_checker u_vrdv_checker (.*);

// ===== bench/vrdv_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdv_access_checker : result checker for the dual-view video memory
// Watches the request and result channels, keeps a shadow copy of the
// memory, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module vrdv_access_checker
    import vrdv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   in_flight
);

    // Shadow of the memory, keyed by word index; only written words exist.
    logic [DATA_W-1:0] vram_shadow [int unsigned];
    rsp_t              rsp_due [$];
    rsp_t              want;
    int                errs = 0;

    assign fail_count = errs;

    // Compute the result word of one access and apply it to the shadow.
    function automatic rsp_t vram_access(req_t r);
        logic [PORT_ADDR_W-1:0] a;
        logic [PORT_ADDR_W-1:0] phys;
        logic [DATA_W-1:0]      word;
        logic [DATA_W-1:0]      lanes;
        logic [DATA_W-1:0]      v;
        int unsigned            key;
        int                     sh;
        rsp_t                   res;
        a = r.address;
        case (r.access_size)
            SIZE_BYTE: lanes = 32'h0000_00FF;
            SIZE_HALF:
            begin
                lanes = 32'h0000_FFFF;
                a[0]  = 1'b0;
            end
            default:
            begin
                lanes   = 32'hFFFF_FFFF;
                a[1:0]  = 2'b00;
            end
        endcase
        // banked view: bit 2 becomes the bank bit, the rest shifts down
        if (r.view == VIEW_BANKED)
            phys = {a[2], a[PORT_ADDR_W-1:3], a[1:0]};
        else
            phys = a;
        key  = 32'(phys[PORT_ADDR_W-1:2]);
        sh   = 8 * int'(phys[1:0]);
        word = vram_shadow.exists(key) ? vram_shadow[key] : '0;
        res.physical_address = phys;
        if (r.req_type == REQ_WRITE)
        begin
            vram_shadow[key] = (word & ~(lanes << sh)) | ((r.write_data & lanes) << sh);
            res.read_data    = '0;
        end
        else
        begin
            v = (word >> sh) & lanes;
            case (r.access_size)
                SIZE_BYTE: res.read_data = {{24{v[7]}}, v[7:0]};
                SIZE_HALF: res.read_data = {{16{v[15]}}, v[15:0]};
                default:   res.read_data = v;
            endcase
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // retire the result word first, then queue the new access
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("result word with none expected: read_data %h physical_address %h",
                           rsp.read_data, rsp.physical_address);
                    errs++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data expected %h actual %h",
                               want.read_data, rsp.read_data);
                        errs++;
                    end
                    if (rsp.physical_address !== want.physical_address)
                    begin
                        $error("physical_address expected %h actual %h",
                               want.physical_address, rsp.physical_address);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                rsp_due.push_back(vram_access(req));
            in_flight <= rsp_due.size();
        end
    end

endmodule

// ===== bench/tb_video_ram_dual_view_access.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_ram_dual_view_access : regression for the dual-view video memory
// Directed accesses over both views, all sizes and the address extremes,
// then random traffic that reads back only bytes already written, with
// random gaps between request words.
// ----------------------------------------------------------------------------
module tb_video_ram_dual_view_access;
    import vrdv_pkg::*;

    // size code with no meaning of its own; the block treats it as a word
    localparam logic [1:0] SIZE_WIDE = 2'd3;
    localparam int N_RANDOM     = 1000;
    localparam int HIST_DEPTH   = 256;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   fail_count;
    int   in_flight;
    int   cycles = 0;

    // physical start and byte count of every recent write
    logic [PORT_ADDR_W-1:0] wr_phys [$];
    int                     wr_bytes [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    video_ram_dual_view_access i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    vrdv_access_checker i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("video_ram_dual_view_access regression: fail");
            $finish;
        end
    end

    function automatic logic [PORT_ADDR_W-1:0] bank_to_flat(logic [PORT_ADDR_W-1:0] a);
        return {a[2], a[PORT_ADDR_W-1:3], a[1:0]};
    endfunction

    function automatic logic [PORT_ADDR_W-1:0] flat_to_bank(logic [PORT_ADDR_W-1:0] p);
        return {p[PORT_ADDR_W-2:2], p[PORT_ADDR_W-1], p[1:0]};
    endfunction

    function automatic int size_bytes(logic [1:0] sz);
        case (sz)
            SIZE_BYTE: return 1;
            SIZE_HALF: return 2;
            default:   return 4;
        endcase
    endfunction

    // Present one request word after a gap and hold it until taken.
    task automatic issue(input logic rt, input logic vw, input logic [1:0] sz,
                         input logic [PORT_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                         input int gap);
        req_t                   r;
        logic [PORT_ADDR_W-1:0] a;
        int                     n;
        r.req_type    = rt;
        r.view        = vw;
        r.access_size = sz;
        r.address     = addr;
        r.write_data  = data;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (rt == REQ_WRITE)
        begin
            n = size_bytes(sz);
            a = addr;
            if (n == 2)
                a[0] = 1'b0;
            if (n == 4)
                a[1:0] = 2'b00;
            wr_phys.push_back(vw == VIEW_BANKED ? bank_to_flat(a) : a);
            wr_bytes.push_back(n);
            if (wr_phys.size() > HIST_DEPTH)
            begin
                void'(wr_phys.pop_front());
                void'(wr_bytes.pop_front());
            end
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    // Read bytes that an earlier write covered, through either view.
    task automatic random_read(input int gap);
        int                     pick;
        int                     wn;
        int                     rn;
        int                     off;
        logic [PORT_ADDR_W-1:0] p;
        logic [PORT_ADDR_W-1:0] addr;
        logic                   vw;
        logic [1:0]             sz;
        pick = $urandom_range(0, wr_phys.size() - 1);
        wn   = wr_bytes[pick];
        rn   = 1 << $urandom_range(0, (wn == 4) ? 2 : ((wn == 2) ? 1 : 0));
        off  = rn * $urandom_range(0, wn / rn - 1);
        p    = wr_phys[pick] + PORT_ADDR_W'(off);
        vw   = 1'($urandom_range(0, 1));
        addr = (vw == VIEW_BANKED) ? flat_to_bank(p) : p;
        // low bits below the access size are dropped by the block
        case (rn)
            1: sz = SIZE_BYTE;
            2:
            begin
                sz      = SIZE_HALF;
                addr[0] = 1'($urandom_range(0, 1));
            end
            default:
            begin
                sz        = $urandom_range(0, 1) ? SIZE_WORD : SIZE_WIDE;
                addr[1:0] = 2'($urandom_range(0, 3));
            end
        endcase
        issue(REQ_READ, vw, sz, addr, $urandom, gap);
    endtask

    task automatic random_write(input int gap);
        logic [PORT_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]      data;
        // keep most writes in a few hot windows so reads overlap them
        case ($urandom_range(0, 3))
            0: addr = PORT_ADDR_W'($urandom_range(0, 63));
            1: addr = 23'h7F_FFFF - PORT_ADDR_W'($urandom_range(0, 63));
            2: addr = 23'h3F_FFE0 + PORT_ADDR_W'($urandom_range(0, 63));
            default: addr = PORT_ADDR_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            2: data = 32'h8080_8080;
            3: data = 32'h7F7F_7F7F;
            default: data = $urandom;
        endcase
        issue(REQ_WRITE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr, data, gap);
    endtask

    initial
    begin
        int gap;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sign bits, lanes and misaligned sizes in the linear view
        issue(REQ_WRITE, VIEW_LINEAR, SIZE_WORD, 23'h00_0000, 32'h8000_0001, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_WORD, 23'h00_0000, 32'hFFFF_FFFF, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h00_0003, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h00_0000, 32'h0000_0000, 1);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_HALF, 23'h00_0003, 32'h0000_0000, 0);
        // top of the window, undefined size code
        issue(REQ_WRITE, VIEW_LINEAR, SIZE_WIDE, 23'h7F_FFFF, 32'hFFFF_FFFF, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h7F_FFFF, 32'h0000_0000, 0);
        // banked view lands in the upper bank
        issue(REQ_WRITE, VIEW_BANKED, SIZE_WORD, 23'h00_0004, 32'h7FFF_FF7F, 2);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_WORD, 23'h40_0000, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_BANKED, SIZE_HALF, 23'h00_0006, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_BANKED, SIZE_BYTE, 23'h00_0004, 32'h0000_0000, 0);
        issue(REQ_WRITE, VIEW_BANKED, SIZE_WIDE, 23'h7F_FFFF, 32'h1234_5678, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_WIDE, 23'h7F_FFFE, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_BANKED, SIZE_HALF, 23'h7F_FFFD, 32'h0000_0000, 3);
        // narrow writes leave the rest of the word alone
        issue(REQ_WRITE, VIEW_LINEAR, SIZE_BYTE, 23'h00_0010, 32'hFFFF_FFAB, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h00_0010, 32'h0000_0000, 0);
        issue(REQ_WRITE, VIEW_LINEAR, SIZE_HALF, 23'h00_0021, 32'h1234_8001, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_HALF, 23'h00_0020, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h00_0021, 32'h0000_0000, 0);
        issue(REQ_WRITE, VIEW_BANKED, SIZE_BYTE, 23'h3F_FFFF, 32'h0000_00FF, 1);
        issue(REQ_READ,  VIEW_LINEAR, SIZE_BYTE, 23'h5F_FFFF, 32'h0000_0000, 0);
        issue(REQ_WRITE, VIEW_LINEAR, SIZE_WORD, 23'h00_0000, 32'h0000_0000, 0);
        issue(REQ_READ,  VIEW_BANKED, SIZE_WORD, 23'h00_0000, 32'h0000_0000, 0);
        drain();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // alternate back-to-back stretches with gappy ones
            gap = (((i / 64) % 3) == 0) ? 0 : $urandom_range(0, 10);
            if (i == N_RANDOM / 2)
                drain();
            if (wr_phys.size() == 0 || $urandom_range(0, 99) < 45)
                random_write(gap);
            else
                random_read(gap);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("video_ram_dual_view_access regression: pass");
        else
            $display("video_ram_dual_view_access regression: fail");
        $finish;
    end

endmodule
